// ===== rtl/core/rid_enc_pkg.sv =====
// ----------------------------------------------------------------------------
// rid_enc_pkg
// Shared types, constants and digit alphabets for the radix 94 / 64 id encoder.
// ----------------------------------------------------------------------------
package rid_enc_pkg;

  localparam int unsigned ValueW  = 128;
  localparam int unsigned ChunkW  = 16;
  localparam int unsigned NumChnk = ValueW / ChunkW;
  localparam int unsigned IdxW    = $clog2(NumChnk);
  localparam int unsigned DigitW  = 6;
  localparam int unsigned RemW    = 7;
  localparam int unsigned CharW   = 7;

  // reciprocal of 94 scaled by 2**30, exact after one correction step
  localparam int unsigned CurW       = RemW + ChunkW;
  localparam int unsigned RecipW     = 24;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned ProdW      = CurW + RecipW;
  localparam logic [RecipW-1:0] RecipM = 24'd11422785;
  localparam logic [RemW-1:0]   Base94 = 7'd94;

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StMul,
    StCorr
  } state_e;

  function automatic logic [CharW-1:0] alpha_char(input logic b94, input logic [RemW-1:0] idx);
    logic [CharW-1:0] ch;
    ch = '0;
    if (idx < 7'd10) begin
      ch = 7'(idx + 7'd48);
    end else if (idx < 7'd36) begin
      ch = 7'(idx + 7'd87);
    end else if (idx < 7'd62) begin
      ch = 7'(idx + 7'd29);
    end else if (!b94) begin
      ch = (idx == 7'd62) ? 7'd95 : 7'd45;
    end else if (idx < 7'd77) begin
      ch = 7'(idx - 7'd29);
    end else if (idx < 7'd84) begin
      ch = 7'(idx - 7'd19);
    end else if (idx == 7'd84) begin
      ch = 7'd91;
    end else if (idx == 7'd85) begin
      ch = 7'd93;
    end else if (idx == 7'd86) begin
      ch = 7'd92;
    end else if (idx < 7'd90) begin
      ch = 7'(idx + 7'd7);
    end else begin
      ch = 7'(idx + 7'd33);
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/rid_enc_div94.sv =====
// ----------------------------------------------------------------------------
// rid_enc_div94
// Divide-by-94 step on one 16-bit chunk with a carried remainder.
// ----------------------------------------------------------------------------
module rid_enc_div94 import rid_enc_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [RemW-1:0]   rem_i,
  input  logic [ChunkW-1:0] chunk_i,
  output logic [ChunkW-1:0] quot_o,
  output logic [RemW-1:0]   rem_o
);

  logic [CurW-1:0]  cur_d;
  logic [CurW-1:0]  cur_q;
  logic [ProdW-1:0] prod_q;
  logic [ChunkW-1:0] q0;
  logic [RemW:0]     r0;
  logic [CurW-1:0]   q0_times;

  assign cur_d = {rem_i, chunk_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cur_q  <= cur_d;
      prod_q <= ProdW'(cur_d) * ProdW'(RecipM);
    end
  end

  // estimate is the quotient or one below it
  always_comb begin
    q0       = prod_q[RecipShift +: ChunkW];
    q0_times = CurW'(q0) * CurW'(Base94);
    r0       = (RemW+1)'(cur_q - q0_times);
    if (r0 >= {1'b0, Base94}) begin
      quot_o = q0 + ChunkW'(1);
      rem_o  = RemW'(r0 - {1'b0, Base94});
    end else begin
      quot_o = q0;
      rem_o  = RemW'(r0);
    end
  end

endmodule

// ===== rtl/core/radix94_or_64_id_encoder.sv =====
// ----------------------------------------------------------------------------
// radix94_or_64_id_encoder
// Converts a 128-bit id into ASCII digits, least significant digit first.
// ----------------------------------------------------------------------------
// base 64: one digit per cycle unless stalled, up to 22 digits, then ready
// base 94: each digit runs the 8 chunks of 16 bits, top chunk first, through
//   the shared divide-by-94 unit (StMul, then StCorr), up to 20 digits
// a zero id gives one empty item, loaded into the output register on accept
// the block takes no new item until the last digit is in the output register
// asynchronous active-low reset clears control state and selects base 64
module radix94_or_64_id_encoder import rid_enc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [63:0]       value_low_i,
  input  logic [63:0]       value_high_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CharW-1:0]  digit_char_o,
  output logic              last_o,
  output logic              empty_res_o
);

  state_e state_q, state_d;

  logic              use_b94_q;
  logic [ValueW-1:0] val_q, val_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [IdxW-1:0]   idx_q, idx_d;

  logic              out_valid_q;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;
  logic              out_load;

  logic              can_emit;
  logic              in_acc;
  logic              in_zero;
  logic              shift_zero;
  logic              new_zero;
  logic              div_load;
  logic [ChunkW-1:0] div_quot;
  logic [RemW-1:0]   div_rem;
  logic [ChunkW-1:0] cur_chunk;

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !can_emit;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_zero    = (value_low_i == '0) && (value_high_i == '0);
  assign shift_zero = (val_q[ValueW-1:DigitW] == '0);
  assign new_zero   = (val_q[ValueW-1:ChunkW] == '0) && (div_quot == '0);
  assign cur_chunk  = val_q[{idx_q, 4'b0000} +: ChunkW];
  assign cfg_ready_o = 1'b1;

  rid_enc_div94 u_div (
    .clk_i   (clk_i),
    .load_i  (div_load),
    .rem_i   (rem_q),
    .chunk_i (cur_chunk),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && !in_zero) begin
          state_d = use_b94_q ? StMul : StShift;
        end
      end
      StShift: begin
        if (can_emit && shift_zero) begin
          state_d = StIdle;
        end
      end
      StMul: begin
        state_d = StCorr;
      end
      StCorr: begin
        if (idx_q != '0) begin
          state_d = StMul;
        end else if (can_emit) begin
          state_d = new_zero ? StIdle : StMul;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    val_d       = val_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    div_load    = 1'b0;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          val_d = {value_high_i, value_low_i};
          rem_d = '0;
          idx_d = '1;
          if (in_zero) begin
            out_load    = 1'b1;
            out_char_d  = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
          end
        end
      end
      StShift: begin
        if (can_emit) begin
          out_load    = 1'b1;
          out_char_d  = alpha_char(1'b0, {1'b0, val_q[DigitW-1:0]});
          out_last_d  = shift_zero;
          out_empty_d = 1'b0;
          val_d       = val_q >> DigitW;
        end
      end
      StMul: begin
        div_load = 1'b1;
      end
      StCorr: begin
        if (idx_q != '0) begin
          val_d[{idx_q, 4'b0000} +: ChunkW] = div_quot;
          rem_d = div_rem;
          idx_d = idx_q - IdxW'(1);
        end else if (can_emit) begin
          val_d[{idx_q, 4'b0000} +: ChunkW] = div_quot;
          rem_d       = '0;
          idx_d       = '1;
          out_load    = 1'b1;
          out_char_d  = alpha_char(1'b1, div_rem);
          out_last_d  = new_zero;
          out_empty_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      use_b94_q   <= 1'b0;
      rem_q       <= '0;
      idx_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        use_b94_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;
  assign empty_res_o  = out_empty_q;

endmodule

// ===== rtl/core/rid_enc_checker.sv =====
// ----------------------------------------------------------------------------
// rid_enc_checker
// Port-level checks for the radix 94 / 64 id encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rid_enc_checker import rid_enc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [63:0]      value_low_i,
  input logic [63:0]      value_high_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CharW-1:0] digit_char_o,
  input logic             last_o,
  input logic             empty_res_o
);

  // stalled item stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_char_o))
    else $error("stalled output item changed");

  // empty item is a single last item with a zero char
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o && (digit_char_o == '0))
    else $error("empty item malformed");

  // digit chars are printable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_res_o |-> (digit_char_o >= 7'd33) && (digit_char_o <= 7'd126))
    else $error("digit char out of alphabet");

  // an accepted nonzero id blocks input in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((value_low_i != '0) || (value_high_i != '0))
      |=> in_stall_o)
    else $error("input taken while busy");

endmodule

bind radix94_or_64_id_encoder rid_enc_checker u_rid_enc_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// radix94_or_64_id_encoder testbench
// Sends 128-bit ids through the encoder in base 64 and base 94 mode. Each id
// is predicted as a string of ASCII digits, least significant first, and the
// digits that come out are compared one by one. Both sides idle and stall at
// random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rid_enc_pkg::*;

  localparam logic MODE_B64 = 1'b0;
  localparam logic MODE_B94 = 1'b1;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SETTLE_TICKS = 400;
  localparam int unsigned HOLD_TICKS   = 400;
  localparam int unsigned PHASE_ITEMS  = 55;
  localparam logic [5:0]  PHASE_MODES  = 6'b101001;

  localparam string DIGITS62 =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string TAIL94 = "!\"#$%&'()*+,-./:;<=>?@[]\\^_\140{|}~";
  localparam string TAIL64 = "_-";

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             empty;
  } digit_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_valid_i  = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_data_i   = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [63:0]      value_low_i  = '0;
  logic [63:0]      value_high_i = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [CharW-1:0] digit_char_o;
  logic             last_o;
  logic             empty_res_o;

  logic [127:0] ids_waiting[$];
  digit_t       digits_due[$];
  logic         base94_mode = MODE_B64;
  logic         quiet_send  = 1'b0;
  logic         quiet_recv  = 1'b0;
  int unsigned  send_gap    = 0;
  int unsigned  recv_gap    = 0;
  int unsigned  hold_asked  = 0;
  int unsigned  hold_given  = 0;
  int unsigned  hold_left   = 0;
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;
  logic         seen_valid  = 1'b0;
  digit_t       seen_digit  = '0;

  radix94_or_64_id_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_low_i  (value_low_i),
    .value_high_i (value_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [CharW-1:0] glyph(input logic b94, input int unsigned r);
    byte c;
    if (r < 62) begin
      c = DIGITS62[r];
    end else if (b94) begin
      c = TAIL94[r-62];
    end else begin
      c = TAIL64[r-62];
    end
    return CharW'(c);
  endfunction

  task automatic queue_digits(input logic [127:0] id);
    logic [127:0] rest;
    int unsigned  radix;
    int unsigned  r;
    digit_t       d;
    rest  = id;
    radix = (base94_mode == MODE_B94) ? 94 : 64;
    if (rest == '0) begin
      d.ch    = '0;
      d.last  = 1'b1;
      d.empty = 1'b1;
      digits_due.push_back(d);
    end else begin
      while (rest != '0) begin
        r       = int'(rest % radix);
        rest    = rest / radix;
        d.ch    = glyph(base94_mode, r);
        d.last  = (rest == '0);
        d.empty = 1'b0;
        digits_due.push_back(d);
      end
    end
  endtask

  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned roll;
    if (quiet) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [127:0] random_id();
    logic [127:0] v;
    int unsigned  pick;
    v    = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      v = '0;
    end else if (pick < 8) begin
      v = v >> $urandom_range(1, 127);
    end else if (pick == 8) begin
      v = {64'd0, v[63:0]};
    end else if (pick == 9) begin
      v = {v[127:64], 64'd0};
    end
    return v;
  endfunction

  // sender
  always @(posedge clk_i) begin : feed
    logic [127:0] next_id;
    logic         hand_off;
    if (rst_ni) begin
      hand_off = in_valid_i && !in_stall_o;
      if (hand_off) begin
        queue_digits({value_high_i, value_low_i});
      end
      if (!in_valid_i || hand_off) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (ids_waiting.size() != 0) begin
          next_id = ids_waiting.pop_front();
          in_valid_i   <= 1'b1;
          value_low_i  <= next_id[63:0];
          value_high_i <= next_id[127:64];
          send_gap = pick_gap(quiet_send);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left  <= HOLD_TICKS;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver, checks the item taken at the previous edge
  always @(posedge clk_i) begin : drain_out
    digit_t want;
    logic   stall_now;
    if (rst_ni) begin
      if (seen_valid) begin
        if (digits_due.size() == 0) begin
          $error("unexpected item: digit_char %0d last %0b empty_res %0b",
                 seen_digit.ch, seen_digit.last, seen_digit.empty);
          fail_count++;
        end else begin
          want = digits_due.pop_front();
          if (seen_digit.ch !== want.ch) begin
            $error("digit_char: expected %0d, got %0d", want.ch, seen_digit.ch);
            fail_count++;
          end
          if (seen_digit.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, seen_digit.last);
            fail_count++;
          end
          if (seen_digit.empty !== want.empty) begin
            $error("empty_res: expected %0b, got %0b", want.empty, seen_digit.empty);
            fail_count++;
          end
        end
      end
      seen_valid <= out_valid_o && !out_stall_i;
      seen_digit <= '{ch: digit_char_o, last: last_o, empty: empty_res_o};
      if (recv_gap != 0) begin
        recv_gap--;
        stall_now = 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 30) begin
          recv_gap = pick_gap(quiet_recv);
        end
        stall_now = (recv_gap != 0);
      end
      out_stall_i <= stall_now || (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (ids_waiting.size() != 0 || in_valid_i || digits_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_mode(input logic b94);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= b94;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    base94_mode = b94;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // base 64 after reset
    ids_waiting.push_back(128'd0);
    ids_waiting.push_back(128'd1);
    ids_waiting.push_back(128'd62);
    ids_waiting.push_back(128'd63);
    ids_waiting.push_back(128'd64);
    ids_waiting.push_back({128{1'b1}});
    ids_waiting.push_back({1'b1, 127'd0});
    ids_waiting.push_back({64'd0, {64{1'b1}}});
    ids_waiting.push_back({{64{1'b1}}, 64'd0});
    ids_waiting.push_back({64{2'b01}});

    write_mode(MODE_B94);
    @(negedge clk_i);
    ids_waiting.push_back(128'd0);
    ids_waiting.push_back(128'd1);
    ids_waiting.push_back(128'd61);
    ids_waiting.push_back(128'd62);
    ids_waiting.push_back(128'd63);
    ids_waiting.push_back(128'd93);
    ids_waiting.push_back(128'd94);
    ids_waiting.push_back({128{1'b1}});
    ids_waiting.push_back({1'b1, 127'd0});
    ids_waiting.push_back({64'd0, {64{1'b1}}});
    ids_waiting.push_back({64{2'b10}});

    for (ph = 0; ph < 6; ph++) begin
      write_mode(PHASE_MODES[ph]);
      @(negedge clk_i);
      quiet_send = (ph == 4);
      quiet_recv = (ph == 4);
      if (ph == 2) begin
        hold_asked++;
      end
      repeat (PHASE_ITEMS) ids_waiting.push_back(random_id());
    end

    wait_idle();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
